@@ rtl/lrs_pkg.sv @@
`default_nettype none

package lrs_pkg;

	localparam int DEF_TIME_BITS = 32;
	localparam int CFG_DATA_W    = 32;
	localparam int CFG_INDEX_W   = 3;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_RETRY_INTERVAL   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SETTLE           = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CONNECT_TIMEOUT  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_ATTEMPTS     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FALLBACK_TIMEOUT = 3'd4;

	localparam logic [31:0] RST_RETRY_INTERVAL   = 32'd30000;
	localparam logic [31:0] RST_SETTLE           = 32'd1000;
	localparam logic [31:0] RST_CONNECT_TIMEOUT  = 32'd10000;
	localparam logic [3:0]  RST_MAX_ATTEMPTS     = 4'd3;
	localparam logic [31:0] RST_FALLBACK_TIMEOUT = 32'd60000;

	// event kinds
	localparam logic [1:0] REQ_UPDATE  = 2'd0;
	localparam logic [1:0] REQ_START   = 2'd1;
	localparam logic [1:0] REQ_SESSION = 2'd2;

	// phase codes as reported on the result
	localparam logic [1:0] PHASE_CODE_IDLE       = 2'd0;
	localparam logic [1:0] PHASE_CODE_SETTLING   = 2'd1;
	localparam logic [1:0] PHASE_CODE_CONNECTING = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'b001,
		PH_SETTLING   = 3'b010,
		PH_CONNECTING = 3'b100
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] attempts;
		logic       link;
		logic       session;
		logic       online;
		logic       fallback;
	} ctl_t;

	typedef struct packed {
		logic disc;
		logic conn;
	} cmd_t;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		case (ph)
			PH_SETTLING:   code = PHASE_CODE_SETTLING;
			PH_CONNECTING: code = PHASE_CODE_CONNECTING;
			default:       code = PHASE_CODE_IDLE;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

@@ rtl/lrs_step.sv @@
`default_nettype none

module lrs_step import lrs_pkg::*; #(
	parameter int TIME_BITS = DEF_TIME_BITS
) (
	input  wire logic [31:0]          retry_interval_ms,
	input  wire logic [31:0]          settle_ms,
	input  wire logic [31:0]          connect_timeout_ms,
	input  wire logic [3:0]           max_attempts,
	input  wire logic [31:0]          fallback_timeout_ms,
	input  wire logic [1:0]           req_type,
	input  wire logic [TIME_BITS-1:0] now,
	input  wire logic                 link_up,
	input  wire logic                 session_up,
	input  wire ctl_t                 ctl_cur,
	input  wire logic [TIME_BITS-1:0] phase_start_cur,
	input  wire logic [TIME_BITS-1:0] last_seq_cur,
	input  wire logic [TIME_BITS-1:0] last_online_cur,
	output ctl_t                      ctl_nxt,
	output logic [TIME_BITS-1:0]      phase_start_nxt,
	output logic [TIME_BITS-1:0]      last_seq_nxt,
	output logic [TIME_BITS-1:0]      last_online_nxt,
	output cmd_t                      cmd
);

	// wrapped elapsed time against a 32-bit limit, compared wide enough for both
	function automatic logic at_least(input logic [TIME_BITS-1:0] el,
		input logic [31:0] lim);
		return {32'd0, el} >= {{TIME_BITS{1'b0}}, lim};
	endfunction

	always_comb begin
		ctl_nxt         = ctl_cur;
		phase_start_nxt = phase_start_cur;
		last_seq_nxt    = last_seq_cur;
		last_online_nxt = last_online_cur;
		cmd             = '0;

		if (req_type == REQ_SESSION) begin
			ctl_nxt.session = session_up;
		end else begin
			if (req_type == REQ_START)
				last_online_nxt = now;
			if (link_up) begin
				ctl_nxt.phase    = PH_IDLE;
				ctl_nxt.attempts = 4'd0;
			end else begin
				if (req_type == REQ_START || (ctl_nxt.phase == PH_IDLE &&
					at_least(TIME_BITS'(now - last_seq_nxt), retry_interval_ms))) begin
					cmd.disc         = 1'b1;
					ctl_nxt.phase    = PH_SETTLING;
					ctl_nxt.attempts = 4'd0;
					phase_start_nxt  = now;
					last_seq_nxt     = now;
				end
				// a fresh sequence with zero settle time connects in the same step
				if (ctl_nxt.phase == PH_SETTLING) begin
					if (at_least(TIME_BITS'(now - phase_start_nxt), settle_ms)) begin
						ctl_nxt.attempts = 4'(ctl_nxt.attempts + 4'd1);
						cmd.conn         = 1'b1;
						ctl_nxt.phase    = PH_CONNECTING;
						phase_start_nxt  = now;
					end
				end else if (ctl_nxt.phase == PH_CONNECTING) begin
					if (at_least(TIME_BITS'(now - phase_start_nxt), connect_timeout_ms)) begin
						if (ctl_nxt.attempts < max_attempts) begin
							cmd.disc        = 1'b1;
							ctl_nxt.phase   = PH_SETTLING;
							phase_start_nxt = now;
						end else begin
							ctl_nxt.phase    = PH_IDLE;
							ctl_nxt.attempts = 4'd0;
							last_seq_nxt     = now;
						end
					end
				end
			end
		end

		ctl_nxt.link = link_up;
		if (!link_up)
			ctl_nxt.session = 1'b0;
		ctl_nxt.online = link_up & ctl_nxt.session;
		if (ctl_nxt.online) begin
			ctl_nxt.fallback = 1'b0;
			last_online_nxt  = now;
		end else begin
			ctl_nxt.fallback = at_least(TIME_BITS'(now - last_online_nxt), fallback_timeout_ms);
		end
	end

endmodule

`default_nettype wire

@@ rtl/link_reconnect_supervisor.sv @@
// Link reconnect supervisor: takes one event per clock (start, periodic update or
// session change, with a millisecond timestamp and the sampled link status) and
// returns one result per event with the disconnect/connect commands, the phase,
// the attempt count and the link, session, online and fallback flags. An event
// is registered on entry, evaluated against the supervisor state by the step logic
// and its result registered, so a result passes the input register and then the
// result register; a new event can be taken every cycle while req_stall is low, the
// figure being set by the single state update loop through the step logic. A stalled
// result holds the input register, and req_stall rises only when both are occupied.
// Configuration is to be written through cfg_we/cfg_index/cfg_data only while no
// event is in flight; the block does not enforce this. Times wrap modulo 2^TIME_BITS.
`default_nettype none

module link_reconnect_supervisor import lrs_pkg::*; #(
	parameter int TIME_BITS = DEF_TIME_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   req_valid,
	output logic                        req_stall,
	input  wire logic [1:0]             req_type,
	input  wire logic [31:0]            now_ms,
	input  wire logic                   link_up,
	input  wire logic                   session_up,
	output logic                        rsp_valid,
	input  wire logic                   rsp_stall,
	output logic                        issue_disconnect,
	output logic                        issue_connect,
	output logic                        link_connected,
	output logic                        session_connected,
	output logic                        online,
	output logic                        fallback_active,
	output logic [1:0]                  phase,
	output logic [3:0]                  attempt_count
);

	logic [31:0] retry_interval_q;
	logic [31:0] settle_q;
	logic [31:0] connect_timeout_q;
	logic [3:0]  max_attempts_q;
	logic [31:0] fallback_timeout_q;

	logic                 valid_s1;
	logic [1:0]           req_type_s1;
	logic [31:0]          now_s1;
	logic                 link_s1;
	logic                 session_s1;

	ctl_t                 ctl_q;
	logic [TIME_BITS-1:0] phase_start_q;
	logic [TIME_BITS-1:0] last_seq_q;
	logic [TIME_BITS-1:0] last_online_q;

	ctl_t                 ctl_nxt;
	logic [TIME_BITS-1:0] phase_start_nxt;
	logic [TIME_BITS-1:0] last_seq_nxt;
	logic [TIME_BITS-1:0] last_online_nxt;
	cmd_t                 cmd;

	logic                 rsp_valid_q;
	cmd_t                 cmd_q;
	ctl_t                 rsp_ctl_q;

	logic [TIME_BITS+31:0] now_wide;
	logic [TIME_BITS-1:0]  now_t;
	logic                  advance;
	logic                  req_accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_interval_q   <= RST_RETRY_INTERVAL;
			settle_q           <= RST_SETTLE;
			connect_timeout_q  <= RST_CONNECT_TIMEOUT;
			max_attempts_q     <= RST_MAX_ATTEMPTS;
			fallback_timeout_q <= RST_FALLBACK_TIMEOUT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RETRY_INTERVAL:   retry_interval_q   <= cfg_data;
				REG_SETTLE:           settle_q           <= cfg_data;
				REG_CONNECT_TIMEOUT:  connect_timeout_q  <= cfg_data;
				REG_MAX_ATTEMPTS:     max_attempts_q     <= cfg_data[3:0];
				REG_FALLBACK_TIMEOUT: fallback_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// the result register frees up when empty or being taken this cycle
	assign advance    = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall  = valid_s1 && !advance;
	assign req_accept = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_type_s1 <= req_type;
			now_s1      <= now_ms;
			link_s1     <= link_up;
			session_s1  <= session_up;
		end
	end

	assign now_wide = {{TIME_BITS{1'b0}}, now_s1};
	assign now_t    = now_wide[TIME_BITS-1:0];

	lrs_step #(
		.TIME_BITS(TIME_BITS)
	) u_step (
		.retry_interval_ms  (retry_interval_q),
		.settle_ms          (settle_q),
		.connect_timeout_ms (connect_timeout_q),
		.max_attempts       (max_attempts_q),
		.fallback_timeout_ms(fallback_timeout_q),
		.req_type           (req_type_s1),
		.now                (now_t),
		.link_up            (link_s1),
		.session_up         (session_s1),
		.ctl_cur            (ctl_q),
		.phase_start_cur    (phase_start_q),
		.last_seq_cur       (last_seq_q),
		.last_online_cur    (last_online_q),
		.ctl_nxt            (ctl_nxt),
		.phase_start_nxt    (phase_start_nxt),
		.last_seq_nxt       (last_seq_nxt),
		.last_online_nxt    (last_online_nxt),
		.cmd                (cmd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q         <= '{phase: PH_IDLE, attempts: 4'd0, default: 1'b0};
			phase_start_q <= '0;
			last_seq_q    <= '0;
			last_online_q <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				ctl_q         <= ctl_nxt;
				phase_start_q <= phase_start_nxt;
				last_seq_q    <= last_seq_nxt;
				last_online_q <= last_online_nxt;
				rsp_valid_q   <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_q     <= cmd;
			rsp_ctl_q <= ctl_nxt;
		end
	end

	assign rsp_valid         = rsp_valid_q;
	assign issue_disconnect  = cmd_q.disc;
	assign issue_connect     = cmd_q.conn;
	assign link_connected    = rsp_ctl_q.link;
	assign session_connected = rsp_ctl_q.session;
	assign online            = rsp_ctl_q.online;
	assign fallback_active   = rsp_ctl_q.fallback;
	assign phase             = phase_code(rsp_ctl_q.phase);
	assign attempt_count     = rsp_ctl_q.attempts;

endmodule

`default_nettype wire

@@ rtl/lrs_checker.sv @@
`default_nettype none

module lrs_checker import lrs_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rsp_valid,
	input wire logic       rsp_stall,
	input wire logic       issue_disconnect,
	input wire logic       issue_connect,
	input wire logic       link_connected,
	input wire logic       session_connected,
	input wire logic       online,
	input wire logic       fallback_active,
	input wire logic [1:0] phase,
	input wire logic [3:0] attempt_count
);

	// a stalled result stays and holds its contents
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid &&
		$stable({issue_disconnect, issue_connect, link_connected, session_connected,
			online, fallback_active, phase, attempt_count}))
		else $error("stalled result changed");

	// with the link up nothing is commanded
	a_link_up_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && link_connected |-> !issue_disconnect && !issue_connect)
		else $error("activity while link up");

	// online means both flags and no fallback, and session drops with the link
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (online == (link_connected && session_connected)) &&
		!(online && fallback_active) && (link_connected || !session_connected))
		else $error("inconsistent status flags");

	// a connect always leaves the block connecting with at least one attempt
	a_connect_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && issue_connect |-> phase == PHASE_CODE_CONNECTING &&
		attempt_count != 4'd0)
		else $error("connect outside connecting phase");

endmodule

bind link_reconnect_supervisor lrs_checker u_lrs_checker (.*);

`default_nettype wire
